// ===== sv/kvcfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kvcfp_pkg;
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MALFORMED = 3'd1;
	localparam logic [2:0] ST_UNKNOWN   = 3'd2;
	localparam logic [2:0] ST_BAD_KEY   = 3'd3;
	localparam logic [2:0] ST_BAD_VALUE = 3'd4;
	localparam logic [2:0] ST_TRUNCATED = 3'd5;
	localparam logic [2:0] ST_TOO_MANY  = 3'd6;

	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_DEL = 2'd1;
	localparam logic [1:0] OP_GET = 2'd2;
	localparam logic [1:0] OP_MOD = 2'd3;

	localparam logic [23:0] NAME_SET = 24'h534554;
	localparam logic [23:0] NAME_DEL = 24'h44454C;
	localparam logic [23:0] NAME_GET = 24'h474554;
	localparam logic [23:0] NAME_MOD = 24'h4D4F44;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] MAX_CMD_RESET = 8'd5;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  operation;
		logic [31:0] key_word;
		logic [31:0] value_word;
		logic [7:0]  command_index;
		logic        request_end;
	} reply_t;

	// Finished command snapshot handed from the front to the back.
	typedef struct packed {
		logic        truncated;  // this entry is a truncation/too-many report only
		logic [2:0]  fixed_status;
		logic [2:0]  token_count;
		logic        name_long;
		logic [23:0] name_chars;
		logic [31:0] key_word;
		logic [31:0] value_word;
		logic [7:0]  command_index;
		logic        request_end;
	} cmd_t;
endpackage
`default_nettype wire

// ===== sv/kvcfp_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface kvcfp_stream_if #(parameter int Width = 8);
	logic             valid;
	logic             ready;
	logic [Width-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/kvcfp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Byte parser: one byte per cycle while the queue has room for two entries, emits up to two command snapshots per byte.
module kvcfp_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	output logic                      byte_ready,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 end_of_read,
	input  wire logic [7:0]           max_commands,
	output logic                      cmd_a_valid,
	output kvcfp_pkg::cmd_t           cmd_a,
	output logic                      cmd_b_valid,
	output kvcfp_pkg::cmd_t           cmd_b,
	input  wire logic                 space_two
);
	typedef enum logic [1:0] {PH_COUNT, PH_LENGTH, PH_TEXT, PH_DISCARD} phase_t;

	phase_t      phase_q;
	logic [7:0]  cmds_left_q, bytes_left_q, index_q;
	logic [2:0]  tok_cnt_q;
	logic        in_tok_q, ended_q, name_long_q;
	logic [23:0] name_q;
	logic [31:0] key_q, val_q;
	logic [1:0]  nph_q;
	logic        key_neg_q, val_neg_q;

	logic fire;
	assign byte_ready = space_two;
	assign fire = byte_valid && space_two;

	// next-text-state computation
	logic [2:0]  tc_n;
	logic        in_n, end_n, nl_n, kn_n, vn_n;
	logic [23:0] nm_n;
	logic [31:0] k_n, v_n, acc, acc_n;
	logic [1:0]  ph, ph_n;
	logic        neg_set, digit;
	logic [3:0]  dval;

	always_comb begin
		tc_n = tok_cnt_q; in_n = in_tok_q; end_n = ended_q; nl_n = name_long_q;
		nm_n = name_q; k_n = key_q; v_n = val_q; kn_n = key_neg_q; vn_n = val_neg_q;
		ph = nph_q; ph_n = nph_q; neg_set = 1'b0; acc = 32'd0; acc_n = 32'd0;
		digit = data_byte >= 8'h30 && data_byte <= 8'h39;
		dval = data_byte[3:0];
		if (!ended_q) begin
			if (data_byte == 8'd0) begin
				end_n = 1'b1;
			end else if (data_byte == kvcfp_pkg::CH_SPACE) begin
				in_n = 1'b0;
			end else begin
				if (!in_tok_q) begin
					in_n = 1'b1;
					if (tok_cnt_q < 3'd4) tc_n = tok_cnt_q + 3'd1;
					ph = 2'd0;
				end
				ph_n = ph;
				acc = (tc_n == 3'd2) ? key_q : val_q;
				acc_n = acc;
				if (ph == 2'd0) begin
					if (data_byte >= 8'd9 && data_byte <= 8'd13) ph_n = 2'd0;
					else if (data_byte == 8'h2B) ph_n = 2'd1;
					else if (data_byte == 8'h2D) begin ph_n = 2'd1; neg_set = 1'b1; end
					else if (digit) begin acc_n = {28'd0, dval}; ph_n = 2'd2; end
					else ph_n = 2'd3;
				end else if (ph != 2'd3) begin
					if (digit) begin
						acc_n = (acc << 3) + (acc << 1) + {28'd0, dval};
						ph_n = 2'd2;
					end else ph_n = 2'd3;
				end
				if (tc_n == 3'd1) begin
					ph_n = ph;
					if (name_q[23:16] != 8'd0) nl_n = 1'b1;
					else nm_n = {name_q[15:0], data_byte};
				end else if (tc_n == 3'd2) begin
					k_n = acc_n; kn_n = key_neg_q | neg_set;
				end else if (tc_n == 3'd3) begin
					v_n = acc_n; vn_n = val_neg_q | neg_set;
				end else ph_n = ph;
			end
		end
	end

	logic [7:0] bl_dec, cl_dec;
	assign bl_dec = bytes_left_q - 8'd1;
	assign cl_dec = cmds_left_q - 8'd1;

	logic finish, from_len;
	always_comb begin
		finish = 1'b0; from_len = 1'b0;
		if (phase_q == PH_LENGTH && data_byte == 8'd0) begin finish = 1'b1; from_len = 1'b1; end
		if (phase_q == PH_TEXT && bl_dec == 8'd0) finish = 1'b1;
	end

	phase_t ph_after;
	always_comb begin
		ph_after = phase_q;
		unique case (phase_q)
			PH_COUNT: begin
				if (data_byte == 8'd0 || data_byte > max_commands) ph_after = PH_DISCARD;
				else ph_after = PH_LENGTH;
			end
			PH_LENGTH: ph_after = (data_byte == 8'd0) ? ((cl_dec == 8'd0) ? PH_DISCARD : PH_LENGTH)
				: PH_TEXT;
			PH_TEXT: if (bl_dec == 8'd0) ph_after = (cl_dec == 8'd0) ? PH_DISCARD : PH_LENGTH;
			default: ph_after = phase_q;
		endcase
	end

	logic [7:0] idx_after;
	assign idx_after = (phase_q == PH_COUNT) ? 8'd0 : (finish ? index_q + 8'd1 : index_q);

	always_comb begin
		cmd_a = '0; cmd_b = '0; cmd_a_valid = 1'b0; cmd_b_valid = 1'b0;
		if (fire) begin
			if (phase_q == PH_COUNT && data_byte != 8'd0 && data_byte > max_commands) begin
				cmd_a_valid = 1'b1; cmd_a.truncated = 1'b1;
				cmd_a.fixed_status = kvcfp_pkg::ST_TOO_MANY; cmd_a.request_end = 1'b1;
			end else if (finish) begin
				cmd_a_valid = 1'b1;
				cmd_a.token_count = from_len ? 3'd0 : tc_n;
				cmd_a.name_long = from_len ? 1'b0 : nl_n;
				cmd_a.name_chars = from_len ? 24'd0 : nm_n;
				cmd_a.key_word = from_len ? 32'd0 : (kn_n ? 32'd0 - k_n : k_n);
				cmd_a.value_word = from_len ? 32'd0 : (vn_n ? 32'd0 - v_n : v_n);
				cmd_a.command_index = index_q;
				cmd_a.request_end = cl_dec == 8'd0;
			end
			if (end_of_read && (ph_after == PH_LENGTH || ph_after == PH_TEXT)) begin
				cmd_b_valid = 1'b1; cmd_b.truncated = 1'b1;
				cmd_b.fixed_status = kvcfp_pkg::ST_TRUNCATED;
				cmd_b.command_index = idx_after; cmd_b.request_end = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT; cmds_left_q <= '0; bytes_left_q <= '0; index_q <= '0;
			tok_cnt_q <= '0; in_tok_q <= 1'b0; ended_q <= 1'b0; name_long_q <= 1'b0;
			name_q <= '0; key_q <= '0; val_q <= '0; nph_q <= '0;
			key_neg_q <= 1'b0; val_neg_q <= 1'b0;
		end else if (fire) begin
			phase_q <= end_of_read ? PH_COUNT : ph_after;
			index_q <= idx_after;
			if (finish) cmds_left_q <= cl_dec;
			unique case (phase_q)
				PH_COUNT: cmds_left_q <= data_byte;
				PH_LENGTH: begin
					bytes_left_q <= data_byte;
					tok_cnt_q <= '0; in_tok_q <= 1'b0; ended_q <= 1'b0; name_long_q <= 1'b0;
					name_q <= '0; key_q <= '0; val_q <= '0; nph_q <= '0;
					key_neg_q <= 1'b0; val_neg_q <= 1'b0;
				end
				PH_TEXT: begin
					bytes_left_q <= bl_dec;
					tok_cnt_q <= tc_n; in_tok_q <= in_n; ended_q <= end_n; name_long_q <= nl_n;
					name_q <= nm_n; key_q <= k_n; val_q <= v_n; nph_q <= ph_n;
					key_neg_q <= kn_n; val_neg_q <= vn_n;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/kvcfp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Four-entry queue, up to two pushes and one pop per cycle.
module kvcfp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_a,
	input  wire kvcfp_pkg::cmd_t data_a,
	input  wire logic            push_b,
	input  wire kvcfp_pkg::cmd_t data_b,
	output logic                 space_two,
	output logic                 pop_valid,
	output kvcfp_pkg::cmd_t      pop_data,
	input  wire logic            pop
);
	kvcfp_pkg::cmd_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       do_pop;
	logic [1:0] wr1;

	assign pop_valid = cnt_q != 3'd0;
	assign pop_data  = mem_q[rd_q];
	assign do_pop    = pop && pop_valid;
	assign space_two = cnt_q <= 3'd2;
	assign wr1       = push_a ? wr_q + 2'd1 : wr_q;

	always_ff @(posedge clk) begin
		if (push_a) mem_q[wr_q] <= data_a;
		if (push_b) mem_q[wr1] <= data_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			wr_q <= wr1 + {1'b0, push_b};
			if (do_pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push_a} + {2'd0, push_b} - {2'd0, do_pop};
		end
	end
endmodule
`default_nettype wire

// ===== sv/kvcfp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Classifies a finished command and holds the result in an output register.
module kvcfp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	input  wire kvcfp_pkg::cmd_t cmd,
	output logic                 cmd_pop,
	output logic                 res_valid,
	output kvcfp_pkg::reply_t    res,
	input  wire logic            res_ready
);
	kvcfp_pkg::reply_t r;
	logic known;
	logic [1:0] op;

	always_comb begin
		known = 1'b1; op = kvcfp_pkg::OP_SET;
		if (cmd.name_long) known = 1'b0;
		else if (cmd.name_chars == kvcfp_pkg::NAME_SET) op = kvcfp_pkg::OP_SET;
		else if (cmd.name_chars == kvcfp_pkg::NAME_DEL) op = kvcfp_pkg::OP_DEL;
		else if (cmd.name_chars == kvcfp_pkg::NAME_GET) op = kvcfp_pkg::OP_GET;
		else if (cmd.name_chars == kvcfp_pkg::NAME_MOD) op = kvcfp_pkg::OP_MOD;
		else known = 1'b0;
		r = '0;
		r.command_index = cmd.command_index;
		r.request_end = cmd.request_end;
		r.operation = op;
		r.key_word = cmd.key_word;
		r.value_word = cmd.value_word;
		if (cmd.truncated) r.status = cmd.fixed_status;
		else if (cmd.token_count > 3'd3 || cmd.token_count == 3'd0)
			r.status = kvcfp_pkg::ST_MALFORMED;
		else if (!known) r.status = kvcfp_pkg::ST_UNKNOWN;
		else if (cmd.token_count < 3'd2) r.status = kvcfp_pkg::ST_MALFORMED;
		else if (cmd.key_word == 32'd0) r.status = kvcfp_pkg::ST_BAD_KEY;
		else if (op == kvcfp_pkg::OP_SET || op == kvcfp_pkg::OP_MOD) begin
			if (cmd.token_count < 3'd3) r.status = kvcfp_pkg::ST_MALFORMED;
			else if (cmd.value_word == 32'd0) r.status = kvcfp_pkg::ST_BAD_VALUE;
		end else begin
			if (cmd.token_count > 3'd2) r.status = kvcfp_pkg::ST_MALFORMED;
			r.value_word = 32'd0;
		end
		if (r.status != kvcfp_pkg::ST_OK) begin
			r.operation = '0; r.key_word = '0; r.value_word = '0;
		end
	end

	assign cmd_pop = !res_valid || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else if (cmd_pop) res_valid <= cmd_valid;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd_valid) res <= r;
	end
endmodule
`default_nettype wire

// ===== sv/kv_command_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one byte per cycle; a byte is taken whenever the 4-entry command queue has room
// for two entries (a command result plus a truncation report).
// Path: a result passes through the queue, then the output register, after its final byte;
// a truncation report queued behind a command result of the same byte comes out after it.
// Reset: arst_n clears parse state, queue and output valid; max_commands returns to 5.
module kv_command_frame_parser (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kvcfp_stream_if.sink   in_ch,
	kvcfp_stream_if.source out_ch,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata
);
	logic [7:0] max_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_q <= kvcfp_pkg::MAX_CMD_RESET;
		else if (cfg_we) max_q <= cfg_wdata;
	end

	logic a_v, b_v, space_two, q_v, q_pop;
	kvcfp_pkg::cmd_t a_d, b_d, q_d;
	kvcfp_pkg::reply_t res;

	kvcfp_front u_front (
		.clk, .arst_n,
		.byte_valid(in_ch.valid), .byte_ready(in_ch.ready),
		.data_byte(in_ch.payload[7:0]), .end_of_read(in_ch.payload[8]),
		.max_commands(max_q),
		.cmd_a_valid(a_v), .cmd_a(a_d), .cmd_b_valid(b_v), .cmd_b(b_d),
		.space_two
	);

	kvcfp_queue u_queue (
		.clk, .arst_n,
		.push_a(a_v), .data_a(a_d), .push_b(b_v), .data_b(b_d),
		.space_two, .pop_valid(q_v), .pop_data(q_d), .pop(q_pop)
	);

	kvcfp_back u_back (
		.clk, .arst_n,
		.cmd_valid(q_v), .cmd(q_d), .cmd_pop(q_pop),
		.res_valid(out_ch.valid), .res, .res_ready(out_ch.ready)
	);

	assign out_ch.payload = res;
endmodule
`default_nettype wire

// ===== tb/kv_command_frame_parser_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kv_command_frame_parser_tb;
	typedef struct {
		logic [7:0]        data;
		logic              eor;
		logic              known;
		kvcfp_pkg::reply_t want;
	} in_item_t;

	// parse phases
	typedef enum logic [1:0] {FR_COUNT, FR_LENGTH, FR_TEXT, FR_DISCARD} frame_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	kvcfp_stream_if #(.Width(9)) in_ch ();
	kvcfp_stream_if #(.Width($bits(kvcfp_pkg::reply_t))) out_ch ();

	kv_command_frame_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// parser model state
	logic [7:0]  lim_cmds;
	frame_t      fr_phase;
	logic [7:0]  cmds_left;
	logic [7:0]  text_left;
	logic [7:0]  cmd_idx;
	logic [2:0]  tok_cnt;
	logic        in_tok, text_done, name_long;
	logic [23:0] name_buf;
	logic [31:0] key_acc, val_acc;
	logic [1:0]  num_ph;
	logic        key_neg, val_neg;

	kvcfp_pkg::reply_t expected_q[$];
	kvcfp_pkg::reply_t step_res[$];
	in_item_t          stim_q[$];

	int errors = 0;
	int sender_idle = 0;
	int stall_pct = 0;
	logic hold_tog = 0;
	logic hold_seen = 0;
	int hold_left = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	function automatic kvcfp_pkg::reply_t mk(logic [2:0] st, logic [7:0] idx, logic last);
		kvcfp_pkg::reply_t r;
		r = '0;
		r.status = st;
		r.command_index = idx;
		r.request_end = last;
		return r;
	endfunction

	task automatic clear_cmd();
		tok_cnt = 0;
		in_tok = 0;
		text_done = 0;
		name_long = 0;
		name_buf = 0;
		key_acc = 0;
		val_acc = 0;
		num_ph = 0;
		key_neg = 0;
		val_neg = 0;
	endtask

	task automatic number_char(input logic is_val, input logic [7:0] b);
		logic digit;
		logic [31:0] acc;
		digit = (b >= "0" && b <= "9");
		acc = is_val ? val_acc : key_acc;
		if (num_ph == 0) begin
			if (b >= 9 && b <= 13)
				return;
			if (b == "+")
				num_ph = 1;
			else if (b == "-") begin
				num_ph = 1;
				if (is_val) val_neg = 1; else key_neg = 1;
			end else if (digit) begin
				acc = b - "0";
				num_ph = 2;
			end else
				num_ph = 3;
		end else if (num_ph != 3) begin
			if (digit) begin
				acc = acc * 10 + (b - "0");
				num_ph = 2;
			end else
				num_ph = 3;
		end
		if (is_val) val_acc = acc; else key_acc = acc;
	endtask

	task automatic text_char(input logic [7:0] b);
		if (text_done)
			return;
		if (b == 0) begin
			text_done = 1;
			return;
		end
		if (b == kvcfp_pkg::CH_SPACE) begin
			in_tok = 0;
			return;
		end
		if (!in_tok) begin
			in_tok = 1;
			if (tok_cnt < 4) tok_cnt++;
			num_ph = 0;
		end
		if (tok_cnt == 1) begin
			if (name_buf[23:16] != 0) name_long = 1;
			else name_buf = {name_buf[15:0], b};
		end else if (tok_cnt == 2)
			number_char(0, b);
		else if (tok_cnt == 3)
			number_char(1, b);
	endtask

	task automatic close_cmd();
		kvcfp_pkg::reply_t r;
		logic known;
		logic [31:0] k, v;
		r = '0;
		k = key_neg ? -key_acc : key_acc;
		v = val_neg ? -val_acc : val_acc;
		r.status = kvcfp_pkg::ST_OK;
		r.operation = kvcfp_pkg::OP_SET;
		if (tok_cnt > 3 || tok_cnt < 1)
			r.status = kvcfp_pkg::ST_MALFORMED;
		else begin
			known = 1;
			if (name_long) known = 0;
			else if (name_buf == kvcfp_pkg::NAME_SET) r.operation = kvcfp_pkg::OP_SET;
			else if (name_buf == kvcfp_pkg::NAME_DEL) r.operation = kvcfp_pkg::OP_DEL;
			else if (name_buf == kvcfp_pkg::NAME_GET) r.operation = kvcfp_pkg::OP_GET;
			else if (name_buf == kvcfp_pkg::NAME_MOD) r.operation = kvcfp_pkg::OP_MOD;
			else known = 0;
			if (!known) r.status = kvcfp_pkg::ST_UNKNOWN;
			else if (tok_cnt < 2) r.status = kvcfp_pkg::ST_MALFORMED;
			else if (k == 0) r.status = kvcfp_pkg::ST_BAD_KEY;
			else if (r.operation == kvcfp_pkg::OP_SET || r.operation == kvcfp_pkg::OP_MOD) begin
				if (tok_cnt < 3) r.status = kvcfp_pkg::ST_MALFORMED;
				else if (v == 0) r.status = kvcfp_pkg::ST_BAD_VALUE;
			end else begin
				if (tok_cnt > 2) r.status = kvcfp_pkg::ST_MALFORMED;
				v = 0;
			end
		end
		if (r.status == kvcfp_pkg::ST_OK) begin
			r.key_word = k;
			r.value_word = v;
		end else
			r.operation = kvcfp_pkg::OP_SET;
		cmds_left--;
		r.command_index = cmd_idx;
		r.request_end = (cmds_left == 0);
		step_res.push_back(r);
		cmd_idx++;
		fr_phase = (cmds_left == 0) ? FR_DISCARD : FR_LENGTH;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic eor);
		step_res.delete();
		case (fr_phase)
			FR_COUNT: begin
				cmd_idx = 0;
				if (b == 0)
					fr_phase = FR_DISCARD;
				else if (b > lim_cmds) begin
					step_res.push_back(mk(kvcfp_pkg::ST_TOO_MANY, 8'd0, 1'b1));
					fr_phase = FR_DISCARD;
				end else begin
					cmds_left = b;
					fr_phase = FR_LENGTH;
				end
			end
			FR_LENGTH: begin
				clear_cmd();
				text_left = b;
				if (b == 0) close_cmd();
				else fr_phase = FR_TEXT;
			end
			FR_TEXT: begin
				text_char(b);
				text_left--;
				if (text_left == 0) close_cmd();
			end
			default: ;
		endcase
		if (eor) begin
			if (fr_phase == FR_LENGTH || fr_phase == FR_TEXT)
				step_res.push_back(mk(kvcfp_pkg::ST_TRUNCATED, cmd_idx, 1'b1));
			fr_phase = FR_COUNT;
		end
	endtask

	task automatic add(input logic [7:0] b, input logic eor = 0, input logic known = 0,
			input kvcfp_pkg::reply_t want = '0);
		in_item_t it;
		it.data = b;
		it.eor = eor;
		it.known = known;
		it.want = want;
		stim_q.push_back(it);
	endtask

	task automatic add_str(input string s);
		foreach (s[i]) add(s[i]);
	endtask

	task automatic send_all();
		in_item_t it;
		int gap;
		while (stim_q.size() > 0) begin
			it = stim_q.pop_front();
			gap = 0;
			if ($urandom_range(99) < sender_idle) gap = $urandom_range(4, 1);
			if (gap > 0) begin
				in_ch.valid <= 0;
				repeat (gap) @(posedge clk);
			end
			in_ch.valid <= 1;
			in_ch.payload <= {it.eor, it.data};
			do @(posedge clk); while (!in_ch.ready);
			parse_byte(it.data, it.eor);
			if (it.known) expected_q.push_back(it.want);
			else foreach (step_res[i]) expected_q.push_back(step_res[i]);
		end
		in_ch.valid <= 0;
	endtask

	task automatic drain();
		int n;
		n = 0;
		while (expected_q.size() > 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		if (expected_q.size() > 0) begin
			$display("tb: failure");
			$finish;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		lim_cmds = v;
	endtask

	function automatic string num_text();
		case ($urandom_range(11))
			0: return "0";
			1: return $sformatf("-%0d", $urandom_range(999, 1));
			2: return "+";
			3: return "4294967296";
			4: return $sformatf("\t+%0d", $urandom_range(99, 1));
			5: return $sformatf("%0dx", $urandom_range(999, 1));
			6: return "4294967295";
			7: return "-0";
			default: return $sformatf("%0d", $urandom);
		endcase
	endfunction

	function automatic string cmd_text();
		string s, name;
		case ($urandom_range(9))
			0: name = "DEL";
			1: name = "GET";
			2: name = "MOD";
			3: name = "set";
			4: name = "SETX";
			5: name = $sformatf("%c", $urandom_range(126, 33));
			default: name = "SET";
		endcase
		s = name;
		if ($urandom_range(9) != 0) s = {s, " ", num_text()};
		if ($urandom_range(3) != 0) s = {s, "  ", num_text()};
		if ($urandom_range(9) == 0) s = {s, " ", num_text()};
		if ($urandom_range(7) == 0) s = {" ", s, " "};
		return s;
	endfunction

	task automatic add_request();
		int cnt, cut, start, len;
		string s;
		start = stim_q.size();
		if ($urandom_range(19) == 0)
			cnt = 0;
		else if ($urandom_range(9) == 0 && lim_cmds < 255)
			cnt = $urandom_range(255, lim_cmds + 1);
		else
			cnt = $urandom_range(lim_cmds < 4 ? lim_cmds : 4, 1);
		add(8'(cnt));
		if (cnt != 0 && cnt <= lim_cmds) begin
			for (int c = 0; c < cnt; c++) begin
				case ($urandom_range(19))
					0: add(8'd0);
					1: begin
						// random junk text, zero byte included sometimes
						len = $urandom_range(12, 1);
						add(8'(len));
						repeat (len) add(8'($urandom_range(255)));
					end
					2: begin
						s = cmd_text();
						add(8'(s.len() + 3));
						add_str(s);
						add(8'd0);
						add(8'($urandom_range(255)));
						add(8'($urandom_range(255)));
					end
					default: begin
						s = cmd_text();
						add(8'(s.len()));
						add_str(s);
					end
				endcase
			end
			if ($urandom_range(9) == 0) repeat ($urandom_range(3, 1)) add(8'($urandom_range(255)));
		end
		if ($urandom_range(9) == 0 && stim_q.size() - start > 2) begin
			cut = $urandom_range(stim_q.size() - 1, start + 1);
			while (stim_q.size() > cut + 1) void'(stim_q.pop_back());
		end
		stim_q[stim_q.size() - 1].eor = 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= 300;
			out_ch.ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 0;
		end else
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		kvcfp_pkg::reply_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.payload;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	initial begin
		int lims[8];
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		in_ch.valid = 0;
		in_ch.payload = 0;
		lim_cmds = kvcfp_pkg::MAX_CMD_RESET;
		fr_phase = FR_COUNT;
		cmds_left = 0;
		text_left = 0;
		cmd_idx = 0;
		clear_cmd();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset limit of 5 in force
		add(8'd0, 1'b1);
		add(8'd6, 1'b1, 1'b1, mk(kvcfp_pkg::ST_TOO_MANY, 8'd0, 1'b1));
		add(8'd1);
		add(8'd0, 1'b1, 1'b1, mk(kvcfp_pkg::ST_MALFORMED, 8'd0, 1'b1));
		add(8'd2, 1'b1, 1'b1, mk(kvcfp_pkg::ST_TRUNCATED, 8'd0, 1'b1));
		add(8'd1);
		add(8'd7);
		add_str("GET -1");
		add("2", 1'b1);
		add(8'd1);
		add(8'd5);
		add_str("MOD ");
		add("1", 1'b1);
		add(8'd255, 1'b1, 1'b1, mk(kvcfp_pkg::ST_TOO_MANY, 8'd0, 1'b1));
		send_all();

		lims = '{5, 255, 1, 3, 255, 1, 5, 4};
		for (int p = 0; p < 8; p++) begin
			if (p > 0) write_limit(8'(p == 7 ? $urandom_range(254, 2) : lims[p]));
			sender_idle = (p % 4 == 1 || p % 4 == 3) ? (p % 4 == 3 ? 15 : 46) : 0;
			stall_pct = (p % 4 == 2) ? 46 : (p % 4 == 3 ? 15 : 0);
			if (p == 2) hold_tog <= ~hold_tog;
			while (stim_q.size() < 100) add_request();
			send_all();
			if (p == 4) drain();
		end
		stall_pct = 0;
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
sv/kvcfp_pkg.sv
sv/kvcfp_stream_if.sv
sv/kvcfp_front.sv
sv/kvcfp_queue.sv
sv/kvcfp_back.sv
sv/kv_command_frame_parser.sv
tb/kv_command_frame_parser_tb.sv
